// ===== rtl/core/nidat_pkg.sv =====
`default_nettype none

package nidat_pkg;

  // Field widths fixed by the message format.
  localparam int unsigned ID_W      = 7;
  localparam int unsigned UID_W     = 64;
  localparam int unsigned HASH_W    = 48;
  localparam int unsigned UID_BYTES = 16;

  // Default highest node ID kept in the table.
  localparam int unsigned MAX_ID_DEF = 125;

  // 64-bit FNV-1a offset basis. The prime is 2^40 + 0x1b3 and is applied as shifts.
  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_INFO  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_FAIL    = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef struct packed {
    op_e              operation;
    logic [ID_W-1:0]  node_id;
    logic [UID_W-1:0] uid_low;
    logic [UID_W-1:0] uid_high;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] result_id;
    status_e         status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_run;
    logic free_run;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hash_done;
    logic scan_done;
    logic need_free;
    logic free_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/nidat_hash.sv =====
`default_nettype none

module nidat_hash import nidat_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [2*UID_W-1:0]    uid_i,
  output logic      [HASH_W-1:0]     hash_o,
  output logic                       done_o
);

  localparam int unsigned CntW = $clog2(UID_BYTES + 1);

  logic [63:0]        h_q, h_d;
  logic [63:0]        mix;
  logic [2*UID_W-1:0] sh_q;
  logic [CntW-1:0]    cnt_q;

  // One byte per cycle: xor the byte in, then multiply by the FNV prime.
  assign mix = h_q ^ {56'b0, sh_q[7:0]};
  assign h_d = mix + (mix << 1) + (mix << 4) + (mix << 5) + (mix << 7) + (mix << 8)
             + (mix << 40);

  // Byte counter; the unit is finished when it reaches zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(UID_BYTES);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Hash state and the unique ID shifted down a byte per step.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      h_q  <= FNV_BASIS;
      sh_q <= uid_i;
    end else if (cnt_q != '0) begin
      h_q  <= h_d;
      sh_q <= sh_q >> 8;
    end
  end

  // Fold the top byte into the low bits and keep 48 of them.
  assign hash_o = h_q[HASH_W-1:0] ^ {{(HASH_W-8){1'b0}}, h_q[63:56]};
  assign done_o = (cnt_q == '0);

endmodule

`default_nettype wire

// ===== rtl/core/nidat_dp.sv =====
`default_nettype none

module nidat_dp import nidat_pkg::*; #(
  parameter int unsigned MaxId = MAX_ID_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_item_t  in_data_i,
  input  wire dp_cmd_t   cmd_i,
  output dp_sts_t        sts_o,
  output logic           out_valid_o,
  output out_item_t      out_data_o,
  input  wire logic      out_stall_i
);

  localparam int unsigned IdxW = $clog2(MaxId + 1);
  localparam logic [ID_W-1:0] MaxIdV = ID_W'(MaxId);
  localparam logic [ID_W-1:0] OneId  = ID_W'(1);

  // Captured transaction.
  op_e               op_q;
  logic [ID_W-1:0]   nid_q;
  logic [ID_W-1:0]   pref_q;
  logic [ID_W-1:0]   pref_in;

  // Hash unit.
  logic [HASH_W-1:0] hash;
  logic              hash_done;

  // Table storage.
  logic [MaxId:0]    occ_q;
  logic [HASH_W-1:0] mem [MaxId+1];
  logic [HASH_W-1:0] rdata_q;

  // Scan and free search state.
  logic [ID_W-1:0]   scan_q, rd_id_q, match_q;
  logic              rd_vld_q, found_q;
  logic              issue, hit;
  logic [ID_W-1:0]   free_q, free_id_q;
  logic              up_q, free_ok_q;
  logic              free_occ, free_zero, free_hit;

  // Commit decision.
  logic              do_commit;
  logic              nid_bad;
  logic              claim;
  logic [ID_W-1:0]   claim_id;
  logic              release_en;
  out_item_t         res;
  logic              out_vld_q;
  out_item_t         out_q;

  nidat_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.load),
    .uid_i   ({in_data_i.uid_high, in_data_i.uid_low}),
    .hash_o  (hash),
    .done_o  (hash_done)
  );

  // A preferred ID of zero or beyond the table starts the search at the top.
  assign pref_in = (in_data_i.node_id == '0 || in_data_i.node_id > MaxIdV) ?
                   MaxIdV : in_data_i.node_id;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_data_i.operation;
      nid_q  <= in_data_i.node_id;
      pref_q <= pref_in;
    end
  end

  // Lookup scan from the top ID down, one table read a cycle, each compared in the cycle after its read.
  assign issue = cmd_i.scan_run && (scan_q != '0);
  assign hit   = rd_vld_q && occ_q[rd_id_q[IdxW-1:0]] && (rdata_q == hash);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= '0;
      rd_id_q  <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      match_q  <= '0;
    end else if (cmd_i.load) begin
      scan_q   <= MaxIdV;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else if (cmd_i.scan_run) begin
      rd_vld_q <= issue;
      rd_id_q  <= scan_q;
      if (issue) begin
        scan_q <= scan_q - 1'b1;
      end
      if (sts_o.scan_done) begin
        found_q <= hit;
        match_q <= rd_id_q;
      end
    end
  end

  // Free search: up from the preferred ID to the top, then down below it.
  assign free_occ  = occ_q[free_q[IdxW-1:0]];
  assign free_zero = (free_q == '0);
  assign free_hit  = !free_zero && !free_occ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q    <= '0;
      up_q      <= 1'b1;
      free_ok_q <= 1'b0;
      free_id_q <= '0;
    end else if (cmd_i.load) begin
      free_q    <= pref_in;
      up_q      <= 1'b1;
      free_ok_q <= 1'b0;
    end else if (cmd_i.free_run) begin
      if (sts_o.free_done) begin
        free_ok_q <= free_hit;
        free_id_q <= free_q;
      end else if (up_q) begin
        if (free_q == MaxIdV) begin
          up_q   <= 1'b0;
          free_q <= pref_q - 1'b1;
        end else begin
          free_q <= free_q + 1'b1;
        end
      end else begin
        free_q <= free_q - 1'b1;
      end
    end
  end

  // Result and table update for the finished transaction.
  assign do_commit = cmd_i.commit && sts_o.out_free;
  assign nid_bad   = (nid_q == '0) || (nid_q > MaxIdV);

  always_comb begin
    res.result_id = '0;
    res.status    = ST_OK;
    claim         = 1'b0;
    claim_id      = nid_q;
    release_en    = 1'b0;
    priority if (op_q == OP_ALLOC) begin
      if (found_q) begin
        res.result_id = match_q;
      end else if (free_ok_q) begin
        res.result_id = free_id_q;
        claim         = 1'b1;
        claim_id      = free_id_q;
      end else begin
        res.status = ST_FAIL;
      end
    end else if (nid_bad) begin
      res.status = ST_IGNORED;
    end else if (occ_q[nid_q[IdxW-1:0]]) begin
      res.result_id = nid_q;
      if (!(found_q && match_q == nid_q)) begin
        res.status = ST_DUP;
      end
    end else begin
      // A prior record of the same unique ID moves to the reporting node.
      res.result_id = nid_q;
      claim         = 1'b1;
      release_en    = found_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (do_commit) begin
      if (release_en) begin
        occ_q[match_q[IdxW-1:0]] <= 1'b0;
      end
      if (claim) begin
        occ_q[claim_id[IdxW-1:0]] <= 1'b1;
      end
    end
  end

  // Hash store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (do_commit && claim) begin
      mem[claim_id[IdxW-1:0]] <= hash;
    end
    if (issue) begin
      rdata_q <= mem[scan_q[IdxW-1:0]];
    end
  end

  // Output register; a new result may load while the old one is being taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (do_commit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_commit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign sts_o.hash_done = hash_done;
  assign sts_o.scan_done = cmd_i.scan_run && rd_vld_q && (hit || rd_id_q == OneId);
  assign sts_o.need_free = (op_q == OP_ALLOC) && !hit;
  assign sts_o.free_done = cmd_i.free_run && (free_hit || free_zero);
  assign sts_o.out_free  = !out_vld_q || !out_stall_i;

  // The table is never written at ID zero or beyond the top ID.
  a_claim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_commit && claim |-> (claim_id != '0) && (claim_id <= MaxIdV))
    else $error("table claim outside the ID range");

  // A commit only claims an ID that is free.
  a_claim_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_commit && claim |-> !occ_q[claim_id[IdxW-1:0]])
    else $error("claim of an occupied ID");

  // The scan compares only real table entries.
  a_scan_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_run && rd_vld_q |-> (rd_id_q != '0) && (rd_id_q <= MaxIdV))
    else $error("scan compared an entry outside the table");

  // A freed record always belongs to a different ID than the one registered.
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_commit && release_en |-> claim && (match_q != claim_id))
    else $error("record release without a distinct claim");

endmodule

`default_nettype wire

// ===== rtl/core/nidat_ctrl.sv =====
`default_nettype none

module nidat_ctrl import nidat_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  output dp_cmd_t      cmd_o,
  input  wire dp_sts_t sts_i
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_HASH   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_FREE   = 5'b01000,
    S_COMMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Sequencing: hash, lookup scan, optional free search, then commit.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        if (sts_i.hash_done) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_done) begin
          state_d = sts_i.need_free ? S_FREE : S_COMMIT;
        end
      end
      S_FREE: begin
        cmd_o.free_run = 1'b1;
        if (sts_i.free_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // A transaction taken in idle starts the hash in the next cycle.
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> in_stall_o && state_q == S_HASH)
    else $error("block not busy after taking a transaction");

  // The free search follows only a scan that needs it.
  a_free_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN && state_d == S_FREE |-> sts_i.scan_done && sts_i.need_free)
    else $error("free search entered without a failed allocate lookup");

endmodule

`default_nettype wire

// ===== rtl/core/node_id_allocation_table_core.sv =====
`default_nettype none

// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i, in_stall_o   | in_data_i  (operation, node_id, uid)
// out     | output    | out_valid_o, out_stall_i | out_data_o (result_id, status)
//
// One transaction is accepted in idle and hashed one byte per cycle until the hash
// unit reports it done. The lookup scan then reads up to MaxId entries through the
// registered-read hash store, an allocate that finds no match runs the free search
// over the table, and the commit writes the result.
// Reset clears the occupied bits at once; the hash store needs no clearing pass.
// A stalled result holds in the output register; a new transaction is accepted
// meanwhile and waits at commit until the register frees.

module node_id_allocation_table_core import nidat_pkg::*; #(
  parameter int unsigned MaxId = MAX_ID_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_data_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  nidat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  nidat_dp #(
    .MaxId (MaxId)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire
